FILE: design/jms_pkg.sv
// Shared types, widths and joint tables for the joint move speed planner.
// No dependencies; used by jms_div and joint_move_speed_sync.
`default_nettype none
package jms_pkg;

	localparam int NJ = 6;
	localparam int IDX_W = 3;
	localparam int ANG_W = 19;
	localparam int MAG_W = 19;
	localparam int GEAR_W = 6;
	localparam int GEAR5_W = 8;
	localparam int SPD_W = 15;
	localparam int CFG_W = 15;
	localparam int LIM_DEG_W = 11;
	localparam int MUL_A_W = MAG_W + GEAR_W;
	localparam int MUL_B_W = CFG_W + 1;
	localparam int NUM_W = MUL_A_W + MUL_B_W;
	localparam int DEN_W = MAG_W + GEAR5_W;
	localparam int QUO_W = 15;

	localparam int unsigned SPD_MAX = 17408;
	localparam int unsigned SPD_RESET = 7680;

	localparam int JOINT_COUNT_DEF = 6;
	localparam int ANGLE_FRAC_DEF = 8;

	localparam int LIM_LO [NJ] = '{-170, -166, -56, -180, -120, -720};
	localparam int LIM_HI [NJ] = '{170, 1, 91, 180, 120, 720};
	localparam int GEAR [NJ] = '{50, 50, 50, 50, 30, 50};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHK,
		ST_DEN,
		ST_MUL1,
		ST_MUL2,
		ST_DIVS,
		ST_DIVW,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage
`default_nettype wire

FILE: design/jms_div.sv
// Serial restoring divider, one quotient bit per cycle, saturating result.
// Depends on jms_pkg for widths, the saturation limit and request/response structs.
`default_nettype none
module jms_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire jms_pkg::div_req_t req,
	output jms_pkg::div_rsp_t      rsp
);

	localparam int CNT_W = $clog2(jms_pkg::QUO_W);

	logic [jms_pkg::NUM_W-1:0] rem_q;
	logic [jms_pkg::NUM_W-1:0] dsh_q;
	logic [jms_pkg::QUO_W-1:0] quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic                      ovf_q;
	logic                      ovf_start;
	logic                      ge;
	logic [jms_pkg::NUM_W-1:0] diff;

	assign ovf_start = (req.num >> jms_pkg::QUO_W) >= jms_pkg::NUM_W'(req.den);
	assign ge = rem_q >= dsh_q;
	assign diff = rem_q - dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				ovf_q <= ovf_start;
				cnt_q <= CNT_W'(jms_pkg::QUO_W - 1);
				if (ovf_start) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= jms_pkg::NUM_W'(req.den) << (jms_pkg::QUO_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff;
			end
			quo_q <= {quo_q[jms_pkg::QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (ovf_q || (quo_q > jms_pkg::QUO_W'(jms_pkg::SPD_MAX))) begin
			rsp.quo = jms_pkg::QUO_W'(jms_pkg::SPD_MAX);
		end else begin
			rsp.quo = quo_q;
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q && !done_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q)
		else $error("divider finished without done");

	a_quo_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> rsp.quo <= jms_pkg::QUO_W'(jms_pkg::SPD_MAX))
		else $error("quotient above saturation limit");

endmodule
`default_nettype wire

FILE: design/joint_move_speed_sync.sv
// Six-joint synchronized move planner: limit check, lead joint search, speed scaling.
// Depends on jms_pkg and jms_div.
//
// Input channel (in_valid/in_ready): cmd = 1 is a feedback transaction that
// overwrites the present angle of feedback_joint and gives no result;
// cmd = 0 is a move transaction with six target angles.
// Output channel (out_valid/out_ready): one result per move transaction.
// Config channel (cfg_valid/cfg_ready): writes speed_setting, always ready.
// A move scans one joint per cycle (limits, delta, running maximum), then
// one shared multiplier forms the divisor and each joint's dividend, and a
// serial divider yields one quotient bit per cycle. A rejected move, or one
// with a zero lead delta, skips the multiplier and the divider. in_ready is
// low while a move is in work.
// The result waits in an output register; a stalled receiver holds the next
// move at its final step with in_ready low, so feedback transactions wait too.
// Reset clears the present angles, sets speed_setting to 7680 and empties
// the output register.
`default_nettype none
module joint_move_speed_sync #(
	parameter int JOINT_COUNT = jms_pkg::JOINT_COUNT_DEF,
	parameter int ANGLE_FRAC_BITS = jms_pkg::ANGLE_FRAC_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [jms_pkg::CFG_W-1:0]        speed_setting,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             cmd,
	input  wire logic signed [jms_pkg::ANG_W-1:0] target_1,
	input  wire logic signed [jms_pkg::ANG_W-1:0] target_2,
	input  wire logic signed [jms_pkg::ANG_W-1:0] target_3,
	input  wire logic signed [jms_pkg::ANG_W-1:0] target_4,
	input  wire logic signed [jms_pkg::ANG_W-1:0] target_5,
	input  wire logic signed [jms_pkg::ANG_W-1:0] target_6,
	input  wire logic [jms_pkg::IDX_W-1:0]        feedback_joint,
	input  wire logic signed [jms_pkg::ANG_W-1:0] feedback_angle,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  accepted,
	output logic [jms_pkg::SPD_W-1:0]             speed_1,
	output logic [jms_pkg::SPD_W-1:0]             speed_2,
	output logic [jms_pkg::SPD_W-1:0]             speed_3,
	output logic [jms_pkg::SPD_W-1:0]             speed_4,
	output logic [jms_pkg::SPD_W-1:0]             speed_5,
	output logic [jms_pkg::SPD_W-1:0]             speed_6,
	output logic [jms_pkg::IDX_W-1:0]             lead_joint
);

	localparam int NJ_ACT = (JOINT_COUNT < jms_pkg::NJ) ? JOINT_COUNT : jms_pkg::NJ;
	localparam int SCALE = 2 ** ANGLE_FRAC_BITS;
	localparam int LIM_W = jms_pkg::LIM_DEG_W + ANGLE_FRAC_BITS;
	localparam int CMP_W = (LIM_W > jms_pkg::ANG_W) ? LIM_W : jms_pkg::ANG_W;
	localparam logic [jms_pkg::IDX_W-1:0] LAST_IDX = jms_pkg::IDX_W'(NJ_ACT - 1);

	jms_pkg::state_t state_q, state_d;

	logic [jms_pkg::CFG_W-1:0]        cfg_q;
	logic signed [jms_pkg::ANG_W-1:0] pres_q [jms_pkg::NJ];
	logic signed [jms_pkg::ANG_W-1:0] tgt_q [jms_pkg::NJ];
	logic [jms_pkg::MAG_W-1:0]        mag_q [jms_pkg::NJ];
	logic [jms_pkg::SPD_W-1:0]        spd_q [jms_pkg::NJ];
	logic [jms_pkg::IDX_W-1:0]        idx_q;
	logic [jms_pkg::MAG_W-1:0]        maxd_q;
	logic [jms_pkg::IDX_W-1:0]        lead_q;
	logic                             ok_q;
	logic [jms_pkg::DEN_W-1:0]        den_q;
	logic [jms_pkg::NUM_W-1:0]        mul_q;

	logic                             out_valid_q;
	logic                             acc_out_q;
	logic [jms_pkg::SPD_W-1:0]        spd_out_q [jms_pkg::NJ];
	logic [jms_pkg::IDX_W-1:0]        lead_out_q;

	logic                             in_acc;
	logic                             out_free;
	logic                             last;
	logic [jms_pkg::MUL_A_W-1:0]      mul_a;
	logic [jms_pkg::MUL_B_W-1:0]      mul_b;
	logic [jms_pkg::NUM_W-1:0]        mul_p;
	logic signed [jms_pkg::ANG_W:0]   cur_diff;
	logic signed [jms_pkg::ANG_W:0]   cur_neg;
	logic [jms_pkg::MAG_W-1:0]        cur_mag;
	logic signed [CMP_W-1:0]          t_ext;
	logic signed [CMP_W-1:0]          lo_ext;
	logic signed [CMP_W-1:0]          hi_ext;
	logic                             out_lim;
	jms_pkg::div_req_t                div_req;
	jms_pkg::div_rsp_t                div_rsp;

	assign cfg_ready = 1'b1;
	assign in_acc = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign last = idx_q == LAST_IDX;

	assign cur_diff = {tgt_q[idx_q][jms_pkg::ANG_W-1], tgt_q[idx_q]}
		- {pres_q[idx_q][jms_pkg::ANG_W-1], pres_q[idx_q]};
	assign cur_neg = -cur_diff;
	assign cur_mag = cur_diff[jms_pkg::ANG_W] ? cur_neg[jms_pkg::MAG_W-1:0]
		: cur_diff[jms_pkg::MAG_W-1:0];
	assign t_ext = CMP_W'(tgt_q[idx_q]);
	assign lo_ext = CMP_W'(jms_pkg::LIM_LO[idx_q] * SCALE);
	assign hi_ext = CMP_W'(jms_pkg::LIM_HI[idx_q] * SCALE);
	assign out_lim = (t_ext > hi_ext) || (t_ext < lo_ext);

	assign mul_p = jms_pkg::NUM_W'(mul_a) * jms_pkg::NUM_W'(mul_b);

	always_comb begin
		state_d = state_q;
		case (state_q)
			jms_pkg::ST_IDLE: begin
				if (in_acc && !cmd) begin
					state_d = jms_pkg::ST_SCAN;
				end
			end
			jms_pkg::ST_SCAN: begin
				if (last) begin
					state_d = jms_pkg::ST_CHK;
				end
			end
			jms_pkg::ST_CHK: begin
				if (!ok_q || (maxd_q == '0)) begin
					state_d = jms_pkg::ST_EMIT;
				end else begin
					state_d = jms_pkg::ST_DEN;
				end
			end
			jms_pkg::ST_DEN: state_d = jms_pkg::ST_MUL1;
			jms_pkg::ST_MUL1: state_d = jms_pkg::ST_MUL2;
			jms_pkg::ST_MUL2: state_d = jms_pkg::ST_DIVS;
			jms_pkg::ST_DIVS: state_d = jms_pkg::ST_DIVW;
			jms_pkg::ST_DIVW: begin
				if (div_rsp.done) begin
					state_d = last ? jms_pkg::ST_EMIT : jms_pkg::ST_MUL1;
				end
			end
			jms_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = jms_pkg::ST_IDLE;
				end
			end
			default: state_d = jms_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_req.start = 1'b0;
		div_req.num = mul_q;
		div_req.den = den_q;
		case (state_q)
			jms_pkg::ST_IDLE: in_ready = 1'b1;
			jms_pkg::ST_DEN: begin
				mul_a = jms_pkg::MUL_A_W'(maxd_q);
				mul_b = jms_pkg::MUL_B_W'(5 * jms_pkg::GEAR[lead_q]);
			end
			jms_pkg::ST_MUL1: begin
				mul_a = jms_pkg::MUL_A_W'(mag_q[idx_q]);
				mul_b = jms_pkg::MUL_B_W'(jms_pkg::GEAR[idx_q]);
			end
			jms_pkg::ST_MUL2: begin
				mul_a = mul_q[jms_pkg::MUL_A_W-1:0];
				mul_b = {cfg_q, 1'b0};
			end
			jms_pkg::ST_DIVS: div_req.start = 1'b1;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jms_pkg::ST_IDLE;
			cfg_q <= jms_pkg::CFG_W'(jms_pkg::SPD_RESET);
			idx_q <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < jms_pkg::NJ; j++) begin
				pres_q[j] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cfg_q <= speed_setting;
			end
			if (in_acc && cmd && (feedback_joint < jms_pkg::IDX_W'(NJ_ACT))) begin
				pres_q[feedback_joint] <= feedback_angle;
			end
			case (state_q)
				jms_pkg::ST_IDLE: idx_q <= '0;
				jms_pkg::ST_SCAN: idx_q <= last ? '0 : idx_q + 1'b1;
				jms_pkg::ST_DEN: idx_q <= '0;
				jms_pkg::ST_DIVW: begin
					if (div_rsp.done && !last) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: idx_q <= idx_q;
			endcase
			if ((state_q == jms_pkg::ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			jms_pkg::ST_IDLE: begin
				if (in_acc && !cmd) begin
					tgt_q[0] <= target_1;
					tgt_q[1] <= target_2;
					tgt_q[2] <= target_3;
					tgt_q[3] <= target_4;
					tgt_q[4] <= target_5;
					tgt_q[5] <= target_6;
					ok_q <= 1'b1;
					maxd_q <= '0;
					lead_q <= '0;
					for (int j = 0; j < jms_pkg::NJ; j++) begin
						spd_q[j] <= '0;
					end
				end
			end
			jms_pkg::ST_SCAN: begin
				mag_q[idx_q] <= cur_mag;
				if (out_lim) begin
					ok_q <= 1'b0;
				end
				if (cur_mag > maxd_q) begin
					maxd_q <= cur_mag;
					lead_q <= idx_q;
				end
			end
			jms_pkg::ST_DEN: den_q <= mul_p[jms_pkg::DEN_W-1:0];
			jms_pkg::ST_MUL1: mul_q <= mul_p;
			jms_pkg::ST_MUL2: mul_q <= mul_p;
			jms_pkg::ST_DIVW: begin
				if (div_rsp.done) begin
					spd_q[idx_q] <= div_rsp.quo;
				end
			end
			jms_pkg::ST_EMIT: begin
				if (out_free) begin
					acc_out_q <= ok_q;
					lead_out_q <= ok_q ? lead_q : '0;
					for (int j = 0; j < jms_pkg::NJ; j++) begin
						spd_out_q[j] <= spd_q[j];
					end
				end
			end
			default: ok_q <= ok_q;
		endcase
	end

	jms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_valid = out_valid_q;
	assign accepted = acc_out_q;
	assign speed_1 = spd_out_q[0];
	assign speed_2 = spd_out_q[1];
	assign speed_3 = spd_out_q[2];
	assign speed_4 = spd_out_q[3];
	assign speed_5 = spd_out_q[4];
	assign speed_6 = spd_out_q[5];
	assign lead_joint = lead_out_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == jms_pkg::ST_DIVW)
		else $error("divider result outside wait state");

	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == jms_pkg::ST_EMIT)
		else $error("result raised outside emit state");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !acc_out_q |-> (lead_out_q == '0) && (spd_out_q[0] == '0)
			&& (spd_out_q[1] == '0) && (spd_out_q[2] == '0) && (spd_out_q[3] == '0)
			&& (spd_out_q[4] == '0) && (spd_out_q[5] == '0))
		else $error("rejected move carries nonzero fields");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != jms_pkg::ST_IDLE |-> idx_q <= LAST_IDX)
		else $error("joint index beyond active joints");

endmodule
`default_nettype wire

FILE: dv/move_plan_checker.sv
`timescale 1ns / 100ps
// Checker for the joint move speed planner: predicts the result of each move transaction
// from the feedback, move and speed register transactions it sees, and compares results.
// Depends on jms_pkg for port widths; instantiated beside the block by the test top.
module move_plan_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	input  wire logic                             cfg_ready,
	input  wire logic [jms_pkg::CFG_W-1:0]        speed_setting,
	input  wire logic                             in_valid,
	input  wire logic                             in_ready,
	input  wire logic                             cmd,
	input  wire logic signed [jms_pkg::ANG_W-1:0] target_1,
	input  wire logic signed [jms_pkg::ANG_W-1:0] target_2,
	input  wire logic signed [jms_pkg::ANG_W-1:0] target_3,
	input  wire logic signed [jms_pkg::ANG_W-1:0] target_4,
	input  wire logic signed [jms_pkg::ANG_W-1:0] target_5,
	input  wire logic signed [jms_pkg::ANG_W-1:0] target_6,
	input  wire logic [jms_pkg::IDX_W-1:0]        feedback_joint,
	input  wire logic signed [jms_pkg::ANG_W-1:0] feedback_angle,
	input  wire logic                             out_valid,
	input  wire logic                             out_ready,
	input  wire logic                             accepted,
	input  wire logic [jms_pkg::SPD_W-1:0]        speed_1,
	input  wire logic [jms_pkg::SPD_W-1:0]        speed_2,
	input  wire logic [jms_pkg::SPD_W-1:0]        speed_3,
	input  wire logic [jms_pkg::SPD_W-1:0]        speed_4,
	input  wire logic [jms_pkg::SPD_W-1:0]        speed_5,
	input  wire logic [jms_pkg::SPD_W-1:0]        speed_6,
	input  wire logic [jms_pkg::IDX_W-1:0]        lead_joint,
	output int                                    mismatches,
	output int                                    plans_waiting
);

	localparam bit CMD_FEEDBACK = 1'b1;
	localparam int JOINTS = 6;
	localparam int FRAC = 8;
	localparam int PRINT_CAP = 40;
	localparam longint SPEED_CEIL = 17408;
	localparam logic [jms_pkg::CFG_W-1:0] SPEED_AT_RESET = 15'd7680;
	localparam int LO_DEG [JOINTS] = '{-170, -166, -56, -180, -120, -720};
	localparam int HI_DEG [JOINTS] = '{170, 1, 91, 180, 120, 720};
	localparam int REDUCTION [JOINTS] = '{50, 50, 50, 50, 30, 50};

	typedef logic [JOINTS-1:0][jms_pkg::ANG_W-1:0] angle_set_t;

	typedef struct packed {
		logic                                  acc;
		logic [JOINTS-1:0][jms_pkg::SPD_W-1:0] spd;
		logic [jms_pkg::IDX_W-1:0]             lead;
	} move_plan_t;

	logic [jms_pkg::CFG_W-1:0] speed_cfg;
	logic signed [jms_pkg::ANG_W-1:0] present [JOINTS];
	move_plan_t plans_q [$];
	move_plan_t want, got;

	initial mismatches = 0;
	assign plans_waiting = plans_q.size();

	task automatic report_mismatch(input string what, input longint seen, input longint wanted);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t ns: %s is %0d, predicted %0d", $time, what, seen, wanted);
	endtask

	function automatic move_plan_t plan_move(input angle_set_t tg);
		move_plan_t p;
		longint t, d, maxd, den, num, s;
		longint mag [JOINTS];
		int lead;
		bit in_range;
		p = '0;
		in_range = 1'b1;
		maxd = 0;
		lead = 0;
		for (int j = 0; j < JOINTS; j++) begin
			t = longint'($signed(tg[j]));
			if (t > HI_DEG[j] * (1 << FRAC) || t < LO_DEG[j] * (1 << FRAC))
				in_range = 1'b0;
		end
		if (!in_range)
			return p;
		for (int j = 0; j < JOINTS; j++) begin
			d = longint'($signed(tg[j])) - longint'(present[j]);
			mag[j] = (d < 0) ? -d : d;
			if (mag[j] > maxd) begin
				maxd = mag[j];
				lead = j;
			end
		end
		p.acc = 1'b1;
		p.lead = lead[jms_pkg::IDX_W-1:0];
		if (maxd != 0) begin
			den = 5 * maxd * REDUCTION[lead];
			for (int j = 0; j < JOINTS; j++) begin
				num = mag[j] * REDUCTION[j] * longint'(speed_cfg) * 2;
				s = num / den;
				if (s > SPEED_CEIL)
					s = SPEED_CEIL;
				p.spd[j] = s[jms_pkg::SPD_W-1:0];
			end
		end
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_cfg = SPEED_AT_RESET;
			foreach (present[j])
				present[j] = '0;
			plans_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				speed_cfg = speed_setting;
			if (in_valid && in_ready) begin
				if (cmd == CMD_FEEDBACK) begin
					if (feedback_joint < JOINTS)
						present[feedback_joint] = feedback_angle;
				end else begin
					plans_q.push_back(plan_move({target_6, target_5, target_4,
						target_3, target_2, target_1}));
				end
			end
			if (out_valid && out_ready) begin
				got = {accepted, {speed_6, speed_5, speed_4, speed_3, speed_2, speed_1},
					lead_joint};
				if (plans_q.size() == 0) begin
					report_mismatch("result with no move waiting, out_valid", 1, 0);
				end else begin
					want = plans_q.pop_front();
					if (got.acc != want.acc)
						report_mismatch("accepted", got.acc, want.acc);
					for (int j = 0; j < JOINTS; j++)
						if (got.spd[j] != want.spd[j])
							report_mismatch($sformatf("speed_%0d", j + 1), got.spd[j],
								want.spd[j]);
					if (got.lead != want.lead)
						report_mismatch("lead_joint", got.lead, want.lead);
				end
			end
		end
	end

endmodule

FILE: dv/joint_move_speed_sync_test.sv
`timescale 1ns / 100ps
// Test top for joint_move_speed_sync: directed and random move and feedback transactions
// under several speed settings, with bursty input and a stalling receiver.
// Depends on jms_pkg, the block and move_plan_checker.
module joint_move_speed_sync_test;

	localparam bit CMD_MOVE = 1'b0;
	localparam bit CMD_FEEDBACK = 1'b1;
	localparam int JOINTS = 6;
	localparam int UNIT = 256;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 300;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 160;
	localparam int LO_DEG [JOINTS] = '{-170, -166, -56, -180, -120, -720};
	localparam int HI_DEG [JOINTS] = '{170, 1, 91, 180, 120, 720};
	localparam logic [jms_pkg::CFG_W-1:0] PHASE_SPEED [PHASES] =
		'{15'd0, 15'd25600, 15'd1, 15'd32767, 15'd0, 15'd7680};

	typedef struct packed {
		logic                                  cmd;
		logic [JOINTS-1:0][jms_pkg::ANG_W-1:0] tgt;
		logic [jms_pkg::IDX_W-1:0]             fj;
		logic [jms_pkg::ANG_W-1:0]             fa;
	} job_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid, cfg_ready;
	logic [jms_pkg::CFG_W-1:0] speed_setting;
	logic in_valid, in_ready, cmd;
	logic signed [jms_pkg::ANG_W-1:0] target_1, target_2, target_3;
	logic signed [jms_pkg::ANG_W-1:0] target_4, target_5, target_6;
	logic [jms_pkg::IDX_W-1:0] feedback_joint;
	logic signed [jms_pkg::ANG_W-1:0] feedback_angle;
	logic out_valid, out_ready, accepted;
	logic [jms_pkg::SPD_W-1:0] speed_1, speed_2, speed_3, speed_4, speed_5, speed_6;
	logic [jms_pkg::IDX_W-1:0] lead_joint;
	int mismatches, plans_waiting;

	logic signed [jms_pkg::ANG_W-1:0] shadow [JOINTS];
	int burst_left = 0;
	bit hold_rx = 1'b0;

	always #5 clk = ~clk;

	joint_move_speed_sync DUT (.*);

	move_plan_checker plan_check (.*);

	function automatic job_t feedback_job(input int j, input int a);
		job_t it;
		it = '0;
		it.cmd = CMD_FEEDBACK;
		it.fj = 3'(j);
		it.fa = 19'(a);
		return it;
	endfunction

	function automatic job_t move_job(input int a1, a2, a3, a4, a5, a6);
		job_t it;
		it = '0;
		it.cmd = CMD_MOVE;
		it.tgt = {19'(a6), 19'(a5), 19'(a4), 19'(a3), 19'(a2), 19'(a1)};
		return it;
	endfunction

	function automatic job_t random_move(input bit still);
		job_t it;
		int pick;
		it = '0;
		it.cmd = CMD_MOVE;
		for (int j = 0; j < JOINTS; j++) begin
			pick = $urandom_range(0, 9);
			if (still || pick < 2)
				it.tgt[j] = shadow[j];
			else if (pick < 4)
				it.tgt[j] = 19'(int'(shadow[j]) + int'($urandom_range(0, 512)) - 256);
			else
				it.tgt[j] = 19'(LO_DEG[j] * UNIT +
					int'($urandom_range(0, (HI_DEG[j] - LO_DEG[j]) * UNIT)));
		end
		return it;
	endfunction

	function automatic job_t random_feedback();
		int j;
		int a;
		j = $urandom_range(0, JOINTS - 1);
		if ($urandom_range(0, 4) == 0)
			a = int'($urandom);
		else
			a = LO_DEG[j] * UNIT + int'($urandom_range(0, (HI_DEG[j] - LO_DEG[j]) * UNIT));
		return feedback_job(j, a);
	endfunction

	function automatic job_t random_noise();
		job_t it;
		int j;
		it = '0;
		case ($urandom_range(0, 2))
		0: begin
			it.cmd = CMD_MOVE;
			for (int k = 0; k < JOINTS; k++)
				it.tgt[k] = 19'($urandom);
		end
		1: begin
			it.cmd = CMD_FEEDBACK;
			it.fj = 3'($urandom_range(JOINTS, 7));
			it.fa = 19'($urandom);
		end
		default: begin
			it = random_move(1'b0);
			j = $urandom_range(0, JOINTS - 1);
			it.tgt[j] = 19'($urandom_range(0, 1) ? HI_DEG[j] * UNIT + 1 : LO_DEG[j] * UNIT - 1);
		end
		endcase
		return it;
	endfunction

	function automatic job_t random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 38)
			return random_feedback();
		if (pick < 42)
			return random_move(1'b1);
		if (pick < 88)
			return random_move(1'b0);
		return random_noise();
	endfunction

	task automatic offer(input job_t it);
		int gap;
		in_valid <= 1'b1;
		cmd <= it.cmd;
		target_1 <= it.tgt[0];
		target_2 <= it.tgt[1];
		target_3 <= it.tgt[2];
		target_4 <= it.tgt[3];
		target_5 <= it.tgt[4];
		target_6 <= it.tgt[5];
		feedback_joint <= it.fj;
		feedback_angle <= it.fa;
		do @(posedge clk); while (!in_ready);
		if (it.cmd == CMD_FEEDBACK && it.fj < JOINTS)
			shadow[it.fj] = it.fa;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (plans_waiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_speed(input logic [jms_pkg::CFG_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		speed_setting <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int mode, run;
		out_ready = 1'b0;
		forever begin
			if (hold_rx) begin
				out_ready <= 1'b0;
				for (int c = 0; c < RX_HOLD_CYCLES; c++)
					@(posedge clk);
				hold_rx = 1'b0;
			end else begin
				mode = $urandom_range(0, 4);
				run = (mode == 4) ? $urandom_range(1, 40) : $urandom_range(1, 60);
				for (int c = 0; c < run; c++) begin
					case (mode)
					0, 1: out_ready <= 1'b1;
					2: out_ready <= 1'($urandom_range(0, 1));
					3: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= 1'b0;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [jms_pkg::CFG_W-1:0] v;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		speed_setting = '0;
		in_valid = 1'b0;
		cmd = CMD_MOVE;
		target_1 = '0;
		target_2 = '0;
		target_3 = '0;
		target_4 = '0;
		target_5 = '0;
		target_6 = '0;
		feedback_joint = '0;
		feedback_angle = '0;
		foreach (shadow[j])
			shadow[j] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		offer(move_job(0, 0, 0, 0, 0, 0));
		offer(move_job(170 * UNIT, 1 * UNIT, 91 * UNIT, 180 * UNIT, 120 * UNIT, 720 * UNIT));
		offer(move_job(-170 * UNIT, -166 * UNIT, -56 * UNIT, -180 * UNIT, -120 * UNIT,
			-720 * UNIT));
		offer(move_job(0, 1 * UNIT + 1, 0, 0, 0, 0));
		offer(move_job(0, 0, 0, 0, 0, -720 * UNIT - 1));
		offer(move_job(262143, 262143, 262143, 262143, 262143, 262143));
		offer(move_job(-262144, -262144, -262144, -262144, -262144, -262144));
		offer(move_job(2560, -2560, 2560, 0, 0, 0));
		offer(move_job(0, -2560, 2560, -2560, 0, 0));
		offer(feedback_job(0, -262144));
		offer(feedback_job(1, 262143));
		offer(feedback_job(2, 87381));
		offer(feedback_job(3, -1));
		offer(feedback_job(4, 1234));
		offer(feedback_job(5, -184320));
		offer(feedback_job(6, 5000));
		offer(feedback_job(7, -5000));
		offer(move_job(0, 0, 0, 0, 0, 0));
		write_speed(15'd32767);
		offer(feedback_job(1, 0));
		offer(feedback_job(4, -230000));
		offer(move_job(-170 * UNIT, 0, 0, 0, 120 * UNIT, 0));

		for (int p = 0; p < PHASES; p++) begin
			v = (p == 4) ? 15'($urandom_range(2, 25599)) : PHASE_SPEED[p];
			write_speed(v);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == 100)
					hold_rx = 1'b1;
				if (p == 2 && n == 150)
					settle();
				offer(random_item());
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && plans_waiting == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
